// ----- design/mgca_pkg.sv -----
// ----------------------------------------------------------------------------
// Multilevel grid cell assign package
// Shared constants, control structs and the level offset function.
// ----------------------------------------------------------------------------
package mgca_pkg;

  // Grid geometry.
  localparam int MAX_LEVELS = 8;
  localparam int LVL_W      = 3;
  localparam int CELL_W     = 7;
  localparam int IDX_W      = 22;
  localparam int COORD_W    = 32;
  localparam int EXT_W      = 31;
  localparam int DVD_W      = 16;
  localparam int WID_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int LANES      = 6;
  localparam int AXES       = 3;
  localparam int CFG_AW     = 3;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_ULOW_X  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ULOW_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ULOW_Z  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_EXT_X   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_EXT_Y   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_EXT_Z   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_NLEVELS = 3'd6;
  localparam logic [CFG_AW-1:0] REG_JDIST   = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             prep;
    logic             lvl_init;
    logic             step;
    logic             first;
    logic [LVL_W-1:0] shift;
    logic [LVL_W-1:0] lev;
    logic             out_load;
  } mgca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             match;
    logic [LVL_W-1:0] top_lev;
  } mgca_stat_t;

  // Number of cells in all levels coarser than level l: (8^l - 1) / 7.
  function automatic logic [IDX_W-1:0] lvl_offset(input logic [LVL_W-1:0] l);
    logic [IDX_W-1:0] off;
    off = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (i < int'(l)) begin
        off = off + (IDX_W'(1) << (3 * i));
      end
    end
    return off;
  endfunction

endpackage

// ----- design/mgca_ctrl.sv -----
// ----------------------------------------------------------------------------
// Multilevel grid cell assign controller
// Sequences widening, the per-level division steps and the level walk.
// ----------------------------------------------------------------------------
module mgca_ctrl
  import mgca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  output mgca_cmd_t  cmd,
  input  mgca_stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_LVL   = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [LVL_W-1:0] lev_r, lev_nxt;
  logic [LVL_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;
  logic             valid_r, valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    lev_nxt   = lev_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    cmd.lev   = lev_r;
    cmd.shift = first_r ? lev_r : cnt_r;
    cmd.first = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        lev_nxt   = stat.top_lev;
        state_nxt = S_LVL;
      end
      S_LVL: begin
        cmd.lvl_init = 1'b1;
        first_nxt    = 1'b1;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (first_r) begin
          first_nxt = 1'b0;
          if (lev_r == '0) begin
            state_nxt = S_CHECK;
          end else begin
            cnt_nxt = lev_r - LVL_W'(1);
          end
        end else if (cnt_r == '0) begin
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r - LVL_W'(1);
        end
      end
      S_CHECK: begin
        if (stat.match || lev_r == '0) begin
          cmd.out_load = 1'b1;
          valid_nxt    = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          lev_nxt   = lev_r - LVL_W'(1);
          state_nxt = S_LVL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lev_r   <= '0;
      cnt_r   <= '0;
      first_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lev_r   <= lev_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// ----- design/mgca_datapath.sv -----
// ----------------------------------------------------------------------------
// Multilevel grid cell assign datapath
// Configuration registers, box widening and six bit-serial cell dividers.
// ----------------------------------------------------------------------------
module mgca_datapath
  import mgca_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_AW-1:0]         cfg_addr,
  input  logic [COORD_W-1:0]        cfg_wdata,
  input  logic                      in_dataset,
  input  logic signed [COORD_W-1:0] in_low_x,
  input  logic signed [COORD_W-1:0] in_low_y,
  input  logic signed [COORD_W-1:0] in_low_z,
  input  logic signed [COORD_W-1:0] in_high_x,
  input  logic signed [COORD_W-1:0] in_high_y,
  input  logic signed [COORD_W-1:0] in_high_z,
  input  mgca_cmd_t                 cmd,
  output mgca_stat_t                stat,
  output logic                      out_dataset_out,
  output logic [LVL_W-1:0]          out_grid_level,
  output logic [CELL_W-1:0]         out_cell_x,
  output logic [CELL_W-1:0]         out_cell_y,
  output logic [CELL_W-1:0]         out_cell_z,
  output logic [IDX_W-1:0]          out_cell_index
);

  logic [COORD_W-1:0] ulow_r [AXES];
  logic [EXT_W-1:0]   ext_r  [AXES];
  logic [3:0]         nlev_r;
  logic [EXT_W-1:0]   jdist_r;
  logic [LVL_W-1:0]   top_lev;
  logic               lanes_match;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        ulow_r[a] <= '0;
        ext_r[a]  <= '0;
      end
      nlev_r  <= 4'd1;
      jdist_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ULOW_X:  ulow_r[0] <= cfg_wdata;
        REG_ULOW_Y:  ulow_r[1] <= cfg_wdata;
        REG_ULOW_Z:  ulow_r[2] <= cfg_wdata;
        REG_EXT_X:   ext_r[0]  <= cfg_wdata[EXT_W-1:0];
        REG_EXT_Y:   ext_r[1]  <= cfg_wdata[EXT_W-1:0];
        REG_EXT_Z:   ext_r[2]  <= cfg_wdata[EXT_W-1:0];
        REG_NLEVELS: nlev_r    <= cfg_wdata[3:0];
        REG_JDIST:   jdist_r   <= cfg_wdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // Finest level in use, with out-of-range level counts clamped.
  always_comb begin
    if (nlev_r == 4'd0) begin
      top_lev = '0;
    end else if (nlev_r >= 4'(MAX_LEVELS)) begin
      top_lev = LVL_W'(MAX_LEVELS - 1);
    end else begin
      top_lev = LVL_W'(nlev_r - 4'd1);
    end
  end

  assign stat = {lanes_match, top_lev};

  // Box widening by half the join distance, saturating to 32 bits.
  logic [COORD_W-1:0] corner_in [LANES];
  logic [COORD_W:0]   half_ext;
  logic [COORD_W:0]   wsum [LANES];
  logic [COORD_W-1:0] wide_r [LANES];
  logic               ds_r;

  assign corner_in[0] = in_low_x;
  assign corner_in[1] = in_low_y;
  assign corner_in[2] = in_low_z;
  assign corner_in[3] = in_high_x;
  assign corner_in[4] = in_high_y;
  assign corner_in[5] = in_high_z;
  assign half_ext     = (COORD_W+1)'(jdist_r >> 1);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (i < AXES) begin
        wsum[i] = {corner_in[i][COORD_W-1], corner_in[i]} - half_ext;
      end else begin
        wsum[i] = {corner_in[i][COORD_W-1], corner_in[i]} + half_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ds_r <= in_dataset;
      for (int i = 0; i < LANES; i++) begin
        if (wsum[i][COORD_W] != wsum[i][COORD_W-1]) begin
          wide_r[i] <= wsum[i][COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                         : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
          wide_r[i] <= wsum[i][COORD_W-1:0];
        end
      end
    end
  end

  // Offset from the universe low corner, in whole units.
  logic [COORD_W:0]   diff [LANES];
  logic [DVD_W-1:0]   dvd_r [LANES];
  logic               le_r  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff[i] = {wide_r[i][COORD_W-1], wide_r[i]}
              - {ulow_r[i % AXES][COORD_W-1], ulow_r[i % AXES]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      for (int i = 0; i < LANES; i++) begin
        dvd_r[i] <= diff[i][COORD_W-1:FRAC_W];
        le_r[i]  <= diff[i][COORD_W] || (diff[i] == '0);
      end
    end
  end

  // Cell width in whole units at the current level: ceil(extent / 2^(lev+16)).
  logic [EXT_W:0]   wround [AXES];
  logic [EXT_W:0]   wmask;
  logic [WID_W-1:0] w_r [AXES];

  assign wmask = ((EXT_W+1)'(1) << (5'(cmd.lev) + 5'(FRAC_W))) - (EXT_W+1)'(1);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      wround[a] = ({1'b0, ext_r[a]} + wmask) >> (5'(cmd.lev) + 5'(FRAC_W));
    end
  end

  // One quotient bit per lane per step; the first step tests for overflow.
  localparam int TW = WID_W + MAX_LEVELS - 1;
  logic [DVD_W-1:0]  rem_r [LANES];
  logic [CELL_W-1:0] q_r   [LANES];
  logic              ovf_r [LANES];
  logic [TW-1:0]     trial [LANES];
  logic              ge    [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = TW'(w_r[i % AXES]) << cmd.shift;
      ge[i]    = (TW'(rem_r[i]) >= trial[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl_init) begin
      for (int a = 0; a < AXES; a++) begin
        w_r[a] <= wround[a][WID_W-1:0];
      end
      for (int i = 0; i < LANES; i++) begin
        rem_r[i] <= dvd_r[i];
        q_r[i]   <= '0;
        ovf_r[i] <= 1'b0;
      end
    end else if (cmd.step) begin
      for (int i = 0; i < LANES; i++) begin
        if (cmd.first) begin
          ovf_r[i] <= ge[i];
        end else if (ge[i]) begin
          rem_r[i]           <= rem_r[i] - trial[i][DVD_W-1:0];
          q_r[i][cmd.shift]  <= 1'b1;
        end
      end
    end
  end

  // Final cell per lane and the containment check.
  logic [CELL_W:0]   res_full;
  logic [CELL_W-1:0] res_m1;
  logic [CELL_W-1:0] lane_cell [LANES];

  assign res_full = ((CELL_W+1)'(1) << cmd.lev) - (CELL_W+1)'(1);
  assign res_m1   = res_full[CELL_W-1:0];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (le_r[i]) begin
        lane_cell[i] = '0;
      end else if (ovf_r[i]) begin
        lane_cell[i] = res_m1;
      end else begin
        lane_cell[i] = q_r[i];
      end
    end
  end

  assign lanes_match = (lane_cell[0] == lane_cell[3]) && (lane_cell[1] == lane_cell[4])
                    && (lane_cell[2] == lane_cell[5]);

  // Result registers.
  logic [4:0] shift2;
  assign shift2 = {1'b0, cmd.lev, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dataset_out <= ds_r;
      out_grid_level  <= cmd.lev;
      out_cell_x      <= lane_cell[0];
      out_cell_y      <= lane_cell[1];
      out_cell_z      <= lane_cell[2];
      out_cell_index  <= lvl_offset(cmd.lev) + IDX_W'(lane_cell[0])
                       + (IDX_W'(lane_cell[1]) << cmd.lev)
                       + (IDX_W'(lane_cell[2]) << shift2);
    end
  end

endmodule

// ----- design/multilevel_grid_cell_assign_unit.sv -----
// ----------------------------------------------------------------------------
// Multilevel grid cell assign unit
// Maps a widened 3-D box to the finest grid level and cell that contain it.
// ----------------------------------------------------------------------------
// Usage: write the universe corner, extents, level count and join distance
// through cfg_we/cfg_addr/cfg_wdata while the unit is idle. Pulse start with a
// box on the in_ ports while busy is low; the item is taken at that edge.
// busy stays high while the item is worked on. The result appears on the out_
// ports for one cycle with out_valid high; the receiver cannot stall it.
// Steps: a prep state takes the widened box's offsets from the universe
// corner, then the walk runs from the finest level in use toward level 0.
// Each level has a setup state, an overflow test step and one division step
// per quotient bit on six parallel one-bit-per-cycle dividers, one per box
// corner coordinate, and a compare state. One item is in flight at a time,
// and a new one may start in the strobe cycle.
// Reset returns the controller to idle, drops out_valid and restores the
// configuration registers to a zero universe, one level and zero join distance.
// ----------------------------------------------------------------------------
module multilevel_grid_cell_assign_unit
  import mgca_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_AW-1:0]         cfg_addr,
  input  logic [COORD_W-1:0]        cfg_wdata,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_dataset,
  input  logic signed [COORD_W-1:0] in_low_x,
  input  logic signed [COORD_W-1:0] in_low_y,
  input  logic signed [COORD_W-1:0] in_low_z,
  input  logic signed [COORD_W-1:0] in_high_x,
  input  logic signed [COORD_W-1:0] in_high_y,
  input  logic signed [COORD_W-1:0] in_high_z,
  output logic                      out_valid,
  output logic                      out_dataset_out,
  output logic [LVL_W-1:0]          out_grid_level,
  output logic [CELL_W-1:0]         out_cell_x,
  output logic [CELL_W-1:0]         out_cell_y,
  output logic [CELL_W-1:0]         out_cell_z,
  output logic [IDX_W-1:0]          out_cell_index
);

  mgca_cmd_t  cmd;
  mgca_stat_t stat;

  // Sequencer.
  mgca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic and registers.
  mgca_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_dataset      (in_dataset),
    .in_low_x        (in_low_x),
    .in_low_y        (in_low_y),
    .in_low_z        (in_low_z),
    .in_high_x       (in_high_x),
    .in_high_y       (in_high_y),
    .in_high_z       (in_high_z),
    .cmd             (cmd),
    .stat            (stat),
    .out_dataset_out (out_dataset_out),
    .out_grid_level  (out_grid_level),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_cell_z      (out_cell_z),
    .out_cell_index  (out_cell_index)
  );

endmodule

// ----- design/mgca_checker.sv -----
// ----------------------------------------------------------------------------
// Multilevel grid cell assign checker
// Port-level properties of the unit, attached by bind.
// ----------------------------------------------------------------------------
module mgca_checker
  import mgca_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [LVL_W-1:0]  out_grid_level,
  input logic [CELL_W-1:0] out_cell_x
);

  // An accepted item makes the unit busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result ends the work on its item.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result shown while still busy or without work");

  // A cell coordinate lies inside its level.
  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_cell_x} < ((CELL_W+1)'(1) << out_grid_level)))
    else $error("cell coordinate beyond its level");

endmodule

bind multilevel_grid_cell_assign_unit mgca_checker u_mgca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_grid_level (out_grid_level),
  .out_cell_x     (out_cell_x)
);
